/* rtl/core/assert_macros.svh */
//------------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers shared by the block sender modules. They
// compile to nothing when SYNTHESIS is defined.
//------------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Property must hold on every clock edge outside reset.
`define SAB_ASSERT(label, clk, rstn, prop) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("sab assertion failed");

// Condition must never be seen on a clock edge outside reset.
`define SAB_ASSERT_NEVER(label, clk, rstn, cond) \
    label: assert property (@(posedge clk) disable iff (!rstn) !(cond)) \
        else $error("sab forbidden condition seen");

`else

`define SAB_ASSERT(label, clk, rstn, prop)
`define SAB_ASSERT_NEVER(label, clk, rstn, cond)

`endif

`endif

/* rtl/core/sab_pkg.sv */
//------------------------------------------------------------------------------
// sab_pkg
// Constants, codes and types shared by the selective-ack block sender.
//------------------------------------------------------------------------------
package sab_pkg;

    localparam int SEGMENTS_PER_BLOCK = 8;
    localparam int SEGMENT_BYTES      = 1024;
    localparam int QUEUE_DEPTH        = 2;

    localparam int IDX_W = (SEGMENTS_PER_BLOCK > 1) ? $clog2(SEGMENTS_PER_BLOCK) : 1;

    // Field widths.
    localparam int OPCODE_W  = 2;
    localparam int BLOCK_W   = 16;
    localparam int COUNT_W   = 4;
    localparam int LEN_W     = 11;
    localparam int SESSION_W = 16;
    localparam int ACKSEG_W  = 16;
    localparam int KIND_W    = 2;
    localparam int STATUS_W  = 2;
    localparam int RETRY_W   = 4;

    // Input tdata layout, lowest field first.
    localparam int S_BLOCK_LSB = 0;
    localparam int S_COUNT_LSB = S_BLOCK_LSB + BLOCK_W;
    localparam int S_LEN_LSB   = S_COUNT_LSB + COUNT_W;
    localparam int S_SESS_LSB  = S_LEN_LSB + LEN_W;
    localparam int S_ABLK_LSB  = S_SESS_LSB + SESSION_W;
    localparam int S_ASEG_LSB  = S_ABLK_LSB + BLOCK_W;
    localparam int S_USED_W    = S_ASEG_LSB + ACKSEG_W;
    localparam int S_TDATA_W   = ((S_USED_W + 7) / 8) * 8;

    // Output tdata layout, lowest field first.
    localparam int M_USED_W  = BLOCK_W + COUNT_W + LEN_W + STATUS_W;
    localparam int M_TDATA_W = ((M_USED_W + 7) / 8) * 8;

    localparam int CFG_ADDR_W = 1;
    localparam int CFG_DATA_W = 16;

    localparam logic [OPCODE_W-1:0] OP_START   = 2'd0;
    localparam logic [OPCODE_W-1:0] OP_ACK     = 2'd1;
    localparam logic [OPCODE_W-1:0] OP_TIMEOUT = 2'd2;

    localparam logic [KIND_W-1:0] KIND_SEND = 2'd0;
    localparam logic [KIND_W-1:0] KIND_DONE = 2'd1;
    localparam logic [KIND_W-1:0] KIND_FAIL = 2'd2;

    localparam logic [STATUS_W-1:0] STAT_OK         = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_INVALID    = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_DUPLICATE  = 2'd2;
    localparam logic [STATUS_W-1:0] STAT_RETRY_FAIL = 2'd3;

    localparam logic [CFG_ADDR_W-1:0] REG_SESSION_ID  = 1'b0;
    localparam logic [CFG_ADDR_W-1:0] REG_MAX_RETRIES = 1'b1;

    localparam logic [RETRY_W-1:0] MAX_RETRIES_RST = 4'd3;

    typedef logic [SEGMENTS_PER_BLOCK-1:0] seg_mask_t;

    // One job for the output side: a run of segment requests or a block end.
    typedef struct packed {
        logic                is_end;
        logic [BLOCK_W-1:0]  block;
        seg_mask_t           mask;
        logic [COUNT_W-1:0]  total;
        logic [LEN_W-1:0]    flen;
        logic [KIND_W-1:0]   kind;
        logic [STATUS_W-1:0] status;
    } cmd_t;

    typedef enum logic {
        BK_IDLE,
        BK_RUN
    } bk_state_t;

    // Bit i is set for every segment i+1 that belongs to a block of this size.
    function automatic seg_mask_t mask_below(logic [COUNT_W-1:0] total);
        seg_mask_t m;
        for (int i = 0; i < SEGMENTS_PER_BLOCK; i++) begin
            m[i] = (COUNT_W'(i) < total);
        end
        return m;
    endfunction

endpackage

/* rtl/core/selective_ack_block_sender.sv */
//------------------------------------------------------------------------------
// selective_ack_block_sender
// Sender side of a block transfer with selective acknowledgement.
//------------------------------------------------------------------------------
// Input items arrive on the s_ stream: tuser carries the opcode (start block,
// ack received, timeout tick) and tdata the block, segment and ack fields.
// Result items leave on the m_ stream: tuser carries the kind (send segment,
// block finished, block failed), tdata the block number, segment number,
// byte count and status, and tlast marks the final result of one input item.
// Session number and retry limit are set through the cfg_ port. The user must
// write them only while no item is in flight; the block does not enforce it.
// An input item is decoded in the cycle it is accepted and its job enters a
// short queue. When the output register can load, the output sequencer takes
// a job from the queue. A block-end job is loaded into the output register;
// a send job is first latched as a run, and its segment requests then follow
// in ascending order, one result per cycle while the receiver takes them.
// No new job is taken until the run is through. Items that cause no result
// are taken at one per cycle while the queue has room.
// A stalled receiver holds the output register; the queue then fills and
// s_tready drops. Reset is synchronous: it empties the queue, drops any open
// block and restores session 0 and retry limit 3.
//------------------------------------------------------------------------------
module selective_ack_block_sender #(
    parameter int QUEUE_DEPTH = sab_pkg::QUEUE_DEPTH
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_wr_en,
    input  logic [sab_pkg::CFG_ADDR_W-1:0]    cfg_addr,
    input  logic [sab_pkg::CFG_DATA_W-1:0]    cfg_wdata,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // start block number, segment_count, last_length, ack_session,
    // ack_block, ack_segment, then zero fill
    input  logic [sab_pkg::S_TDATA_W-1:0]     s_tdata,
    // opcode
    input  logic [sab_pkg::OPCODE_W-1:0]      s_tuser,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // out_block, segment number, segment_bytes, status, then zero fill
    output logic [sab_pkg::M_TDATA_W-1:0]     m_tdata,
    // kind
    output logic [sab_pkg::KIND_W-1:0]        m_tuser,
    // last_of_run
    output logic                              m_tlast
);
    import sab_pkg::*;

    logic  q_push;
    logic  q_ready;
    cmd_t  q_push_cmd;
    logic  q_pop;
    logic  q_valid;
    cmd_t  q_head;

    sab_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .q_ready   (q_ready),
        .q_push    (q_push),
        .q_cmd     (q_push_cmd)
    );

    sab_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_cmd   (q_push_cmd),
        .push_ready (q_ready),
        .pop        (q_pop),
        .head_cmd   (q_head),
        .head_valid (q_valid)
    );

    sab_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_valid  (q_valid),
        .q_head   (q_head),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule

/* rtl/core/sab_fifo.sv */
//------------------------------------------------------------------------------
// sab_fifo
// Short command queue between the item decoder and the result sequencer.
//------------------------------------------------------------------------------
module sab_fifo #(
    parameter int DEPTH = sab_pkg::QUEUE_DEPTH
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          push,
    input  sab_pkg::cmd_t push_cmd,
    output logic          push_ready,
    input  logic          pop,
    output sab_pkg::cmd_t head_cmd,
    output logic          head_valid
);
    import sab_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    cmd_t             mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic             do_push;
    logic             do_pop;

    assign push_ready = (count_reg != CNT_W'(DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_cmd   = mem_reg[rd_ptr_reg];
    assign do_push    = push && push_ready;
    assign do_pop     = pop && head_valid;

    assign wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
    assign rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= wr_ptr_next;
            end
            if (do_pop) begin
                rd_ptr_reg <= rd_ptr_next;
            end
            if (do_push && !do_pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (do_pop && !do_push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

/* rtl/core/sab_front.sv */
//------------------------------------------------------------------------------
// sab_front
// Accepts input items, keeps the block state and the configuration registers,
// and queues one command for every item that causes results.
//------------------------------------------------------------------------------
`include "assert_macros.svh"

module sab_front (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_wr_en,
    input  logic [sab_pkg::CFG_ADDR_W-1:0]    cfg_addr,
    input  logic [sab_pkg::CFG_DATA_W-1:0]    cfg_wdata,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [sab_pkg::S_TDATA_W-1:0]     s_tdata,
    input  logic [sab_pkg::OPCODE_W-1:0]      s_tuser,
    input  logic                              q_ready,
    output logic                              q_push,
    output sab_pkg::cmd_t                     q_cmd
);
    import sab_pkg::*;

    logic [SESSION_W-1:0] session_reg;
    logic [RETRY_W-1:0]   max_retries_reg;

    logic                 busy_reg;
    logic                 busy_next;
    seg_mask_t            ack_bits_reg;
    seg_mask_t            ack_bits_next;
    logic [COUNT_W-1:0]   seg_total_reg;
    logic [COUNT_W-1:0]   seg_total_next;
    logic [COUNT_W-1:0]   acked_count_reg;
    logic [COUNT_W-1:0]   acked_count_next;
    logic [RETRY_W-1:0]   retry_count_reg;
    logic [RETRY_W-1:0]   retry_count_next;
    logic [BLOCK_W-1:0]   block_reg;
    logic [BLOCK_W-1:0]   block_next;
    logic [LEN_W-1:0]     final_len_reg;
    logic [LEN_W-1:0]     final_len_next;

    logic                 in_fire;
    logic [BLOCK_W-1:0]   in_block;
    logic [COUNT_W-1:0]   in_count;
    logic [LEN_W-1:0]     in_len;
    logic [SESSION_W-1:0] in_ack_sess;
    logic [BLOCK_W-1:0]   in_ack_blk;
    logic [ACKSEG_W-1:0]  in_ack_seg;

    logic [COUNT_W-1:0]   count_sat;
    logic [LEN_W-1:0]     len_sat;
    logic                 ack_range_ok;
    logic [IDX_W-1:0]     ack_idx;
    seg_mask_t            ack_onehot;
    logic [COUNT_W-1:0]   acked_inc;

    assign s_tready = q_ready;
    assign in_fire  = s_tvalid && s_tready;

    assign in_block    = s_tdata[S_BLOCK_LSB +: BLOCK_W];
    assign in_count    = s_tdata[S_COUNT_LSB +: COUNT_W];
    assign in_len      = s_tdata[S_LEN_LSB +: LEN_W];
    assign in_ack_sess = s_tdata[S_SESS_LSB +: SESSION_W];
    assign in_ack_blk  = s_tdata[S_ABLK_LSB +: BLOCK_W];
    assign in_ack_seg  = s_tdata[S_ASEG_LSB +: ACKSEG_W];

    always_comb begin
        if (in_count == '0) begin
            count_sat = COUNT_W'(1);
        end else if (in_count > COUNT_W'(SEGMENTS_PER_BLOCK)) begin
            count_sat = COUNT_W'(SEGMENTS_PER_BLOCK);
        end else begin
            count_sat = in_count;
        end
    end

    assign len_sat = (in_len > LEN_W'(SEGMENT_BYTES)) ? LEN_W'(SEGMENT_BYTES) : in_len;

    // Segments are numbered from one; bit zero of the mask is segment one.
    assign ack_range_ok = (in_ack_seg != '0) && (in_ack_seg <= ACKSEG_W'(seg_total_reg));
    assign ack_idx      = IDX_W'(in_ack_seg - 1'b1);
    assign ack_onehot   = seg_mask_t'(1) << ack_idx;
    assign acked_inc    = acked_count_reg + 1'b1;

    always_comb begin
        busy_next        = busy_reg;
        ack_bits_next    = ack_bits_reg;
        seg_total_next   = seg_total_reg;
        acked_count_next = acked_count_reg;
        retry_count_next = retry_count_reg;
        block_next       = block_reg;
        final_len_next   = final_len_reg;
        q_push           = 1'b0;
        q_cmd.is_end     = 1'b0;
        q_cmd.block      = block_reg;
        q_cmd.mask       = mask_below(seg_total_reg) & ~ack_bits_reg;
        q_cmd.total      = seg_total_reg;
        q_cmd.flen       = final_len_reg;
        q_cmd.kind       = KIND_SEND;
        q_cmd.status     = STAT_OK;

        if (in_fire) begin
            case (s_tuser)
                OP_START: begin
                    busy_next        = 1'b1;
                    ack_bits_next    = '0;
                    seg_total_next   = count_sat;
                    acked_count_next = '0;
                    retry_count_next = '0;
                    block_next       = in_block;
                    final_len_next   = len_sat;
                    q_push           = 1'b1;
                    q_cmd.block      = in_block;
                    q_cmd.mask       = mask_below(count_sat);
                    q_cmd.total      = count_sat;
                    q_cmd.flen       = len_sat;
                end
                OP_ACK: begin
                    if (busy_reg) begin
                        q_cmd.is_end = 1'b1;
                        q_cmd.kind   = KIND_FAIL;
                        if (in_ack_sess != session_reg || in_ack_blk != block_reg
                                || !ack_range_ok) begin
                            busy_next    = 1'b0;
                            q_push       = 1'b1;
                            q_cmd.status = STAT_INVALID;
                        end else if ((ack_bits_reg & ack_onehot) != '0) begin
                            busy_next    = 1'b0;
                            q_push       = 1'b1;
                            q_cmd.status = STAT_DUPLICATE;
                        end else begin
                            ack_bits_next    = ack_bits_reg | ack_onehot;
                            acked_count_next = acked_inc;
                            if (acked_inc >= seg_total_reg) begin
                                busy_next  = 1'b0;
                                q_push     = 1'b1;
                                q_cmd.kind = KIND_DONE;
                            end
                        end
                    end
                end
                OP_TIMEOUT: begin
                    if (busy_reg) begin
                        q_push = 1'b1;
                        if (retry_count_reg >= max_retries_reg) begin
                            busy_next    = 1'b0;
                            q_cmd.is_end = 1'b1;
                            q_cmd.kind   = KIND_FAIL;
                            q_cmd.status = STAT_RETRY_FAIL;
                        end else begin
                            retry_count_next = retry_count_reg + 1'b1;
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            session_reg     <= '0;
            max_retries_reg <= MAX_RETRIES_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                REG_SESSION_ID:  session_reg     <= cfg_wdata[SESSION_W-1:0];
                REG_MAX_RETRIES: max_retries_reg <= cfg_wdata[RETRY_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg        <= 1'b0;
            ack_bits_reg    <= '0;
            seg_total_reg   <= '0;
            acked_count_reg <= '0;
            retry_count_reg <= '0;
            block_reg       <= '0;
            final_len_reg   <= '0;
        end else begin
            busy_reg        <= busy_next;
            ack_bits_reg    <= ack_bits_next;
            seg_total_reg   <= seg_total_next;
            acked_count_reg <= acked_count_next;
            retry_count_reg <= retry_count_next;
            block_reg       <= block_next;
            final_len_reg   <= final_len_next;
        end
    end

    `SAB_ASSERT(a_busy_total_range, aclk, aresetn,
        busy_reg |-> (seg_total_reg != '0 && seg_total_reg <= COUNT_W'(SEGMENTS_PER_BLOCK)))
    `SAB_ASSERT(a_busy_not_complete, aclk, aresetn,
        busy_reg |-> (acked_count_reg < seg_total_reg))
    `SAB_ASSERT_NEVER(a_empty_send_run, aclk, aresetn,
        q_push && !q_cmd.is_end && q_cmd.mask == '0)

endmodule

/* rtl/core/sab_back.sv */
//------------------------------------------------------------------------------
// sab_back
// Takes commands from the queue and emits their results one per cycle into
// the output register while that register can load.
//------------------------------------------------------------------------------
`include "assert_macros.svh"

module sab_back (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            q_valid,
    input  sab_pkg::cmd_t                   q_head,
    output logic                            q_pop,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [sab_pkg::M_TDATA_W-1:0]   m_tdata,
    output logic [sab_pkg::KIND_W-1:0]      m_tuser,
    output logic                            m_tlast
);
    import sab_pkg::*;

    bk_state_t            state_reg;
    bk_state_t            state_next;
    seg_mask_t            remain_reg;
    seg_mask_t            remain_next;
    logic [BLOCK_W-1:0]   blk_reg;
    logic [COUNT_W-1:0]   total_reg;
    logic [LEN_W-1:0]     flen_reg;

    logic                 out_valid_reg;
    logic                 out_valid_next;
    logic [BLOCK_W-1:0]   out_block_reg;
    logic [COUNT_W-1:0]   out_seg_reg;
    logic [LEN_W-1:0]     out_bytes_reg;
    logic [STATUS_W-1:0]  out_status_reg;
    logic [KIND_W-1:0]    out_kind_reg;
    logic                 out_last_reg;

    logic                 out_load;
    logic                 latch_run;
    logic                 emit_end;
    logic                 emit_seg;
    logic [IDX_W-1:0]     first_idx;
    seg_mask_t            first_onehot;
    logic [COUNT_W-1:0]   seg_num;
    logic [LEN_W-1:0]     seg_bytes;
    logic                 seg_last;

    // The output register may take a new result when it is empty or draining.
    assign out_load = !out_valid_reg || m_tready;

    // Lowest segment still owed in the current run.
    always_comb begin
        first_idx = '0;
        for (int i = SEGMENTS_PER_BLOCK - 1; i >= 0; i--) begin
            if (remain_reg[i]) begin
                first_idx = IDX_W'(i);
            end
        end
    end

    assign first_onehot = seg_mask_t'(1) << first_idx;
    assign remain_next  = remain_reg & ~first_onehot;
    assign seg_num      = COUNT_W'(first_idx) + 1'b1;
    assign seg_bytes    = (seg_num == total_reg) ? flen_reg : LEN_W'(SEGMENT_BYTES);
    assign seg_last     = (remain_next == '0);

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            BK_IDLE: begin
                if (q_valid && out_load && !q_head.is_end) begin
                    state_next = BK_RUN;
                end
            end
            BK_RUN: begin
                if (out_load && seg_last) begin
                    state_next = BK_IDLE;
                end
            end
            default: state_next = BK_IDLE;
        endcase
    end

    always_comb begin
        q_pop     = 1'b0;
        latch_run = 1'b0;
        emit_end  = 1'b0;
        emit_seg  = 1'b0;
        unique case (state_reg)
            BK_IDLE: begin
                if (q_valid && out_load) begin
                    q_pop     = 1'b1;
                    emit_end  = q_head.is_end;
                    latch_run = !q_head.is_end;
                end
            end
            BK_RUN: begin
                emit_seg = out_load;
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        if (emit_end || emit_seg) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= BK_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (latch_run) begin
            remain_reg <= q_head.mask;
            blk_reg    <= q_head.block;
            total_reg  <= q_head.total;
            flen_reg   <= q_head.flen;
        end else if (emit_seg) begin
            remain_reg <= remain_next;
        end

        if (emit_end) begin
            out_block_reg  <= q_head.block;
            out_seg_reg    <= '0;
            out_bytes_reg  <= '0;
            out_status_reg <= q_head.status;
            out_kind_reg   <= q_head.kind;
            out_last_reg   <= 1'b1;
        end else if (emit_seg) begin
            out_block_reg  <= blk_reg;
            out_seg_reg    <= seg_num;
            out_bytes_reg  <= seg_bytes;
            out_status_reg <= STAT_OK;
            out_kind_reg   <= KIND_SEND;
            out_last_reg   <= seg_last;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {(M_TDATA_W - M_USED_W)'(0), out_status_reg, out_bytes_reg,
                       out_seg_reg, out_block_reg};
    assign m_tuser  = out_kind_reg;
    assign m_tlast  = out_last_reg;

    `SAB_ASSERT(a_run_has_work, aclk, aresetn,
        (state_reg == BK_RUN) |-> (remain_reg != '0))
    `SAB_ASSERT(a_end_emits_last, aclk, aresetn,
        emit_end |=> (out_valid_reg && out_last_reg && out_kind_reg != KIND_SEND))
    `SAB_ASSERT(a_nonsend_is_last, aclk, aresetn,
        (out_valid_reg && out_kind_reg != KIND_SEND) |-> (out_last_reg && out_seg_reg == '0))

endmodule

/* test/tb_top.sv */
//------------------------------------------------------------------------------
// tb_top
// Self-checking bench for the selective-ack block sender. Each accepted item
// updates a behavioral copy of the sender's state, and that copy queues the
// result items the block should emit. A short directed run covers the edge
// cases. Randomized block transfers follow under several register settings.
// The transfers are mostly well-formed with random content, plus faulty acks,
// timeouts and noise. Both stream sides idle at random.
//------------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import sab_pkg::*;

    localparam logic [OPCODE_W-1:0] OP_RESERVED = 2'd3;
    localparam int SETTLE_CYCLES = 32;
    localparam int CYCLE_LIMIT   = 600000;
    localparam int PHASE_ITEMS   = 57;

    typedef struct {
        logic [OPCODE_W-1:0]  opcode;
        logic [BLOCK_W-1:0]   block;
        logic [COUNT_W-1:0]   count;
        logic [LEN_W-1:0]     len;
        logic [SESSION_W-1:0] sess;
        logic [BLOCK_W-1:0]   ablk;
        logic [ACKSEG_W-1:0]  aseg;
    } sab_item_t;

    typedef struct {
        logic [KIND_W-1:0]   kind;
        logic [BLOCK_W-1:0]  block;
        logic [COUNT_W-1:0]  seg;
        logic [LEN_W-1:0]    bytes;
        logic [STATUS_W-1:0] status;
        logic                last;
    } sab_result_t;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr  = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata   = '0;
    logic [OPCODE_W-1:0]   s_tuser   = '0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic [KIND_W-1:0]     m_tuser;
    logic                  m_tlast;

    // Mirror of the sender's registers and block state.
    logic [SESSION_W-1:0]          session_reg  = '0;
    logic [RETRY_W-1:0]            retry_limit  = MAX_RETRIES_RST;
    logic [SEGMENTS_PER_BLOCK-1:0] ack_bits     = '0;
    logic [COUNT_W-1:0]            seg_total    = '0;
    logic [COUNT_W-1:0]            acked_count  = '0;
    logic [RETRY_W-1:0]            retry_count  = '0;
    logic [BLOCK_W-1:0]            cur_block    = '0;
    logic [LEN_W-1:0]              final_len    = '0;
    logic                          blk_busy     = 1'b0;

    sab_result_t pending_results[$];

    int fail_count    = 0;
    int active_items  = 0;
    int results_seen  = 0;
    int blocks_done   = 0;
    int blocks_failed = 0;
    int cycle_count   = 0;
    bit tx_calm       = 1'b0;
    bit rx_calm       = 1'b0;
    int rx_wait       = 0;

    selective_ack_block_sender DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    //--------------------------------------------------------------------------
    // Behavioral sender
    //--------------------------------------------------------------------------
    function automatic void queue_result(logic [KIND_W-1:0] kind, logic [COUNT_W-1:0] seg,
                                         logic [LEN_W-1:0] bytes, logic [STATUS_W-1:0] status,
                                         logic last);
        sab_result_t r;
        r.kind   = kind;
        r.block  = cur_block;
        r.seg    = seg;
        r.bytes  = bytes;
        r.status = status;
        r.last   = last;
        pending_results.insert(pending_results.size(), r);
    endfunction

    function automatic void close_block(logic [KIND_W-1:0] kind, logic [STATUS_W-1:0] status);
        blk_busy = 1'b0;
        if (kind == KIND_DONE) blocks_done++;
        else blocks_failed++;
        queue_result(kind, '0, '0, status, 1'b1);
    endfunction

    // One send request per unacknowledged segment, in ascending order.
    function automatic void queue_unacked();
        int last_open;
        last_open = 0;
        for (int s = 1; s <= seg_total; s++) begin
            if (!ack_bits[s-1]) last_open = s;
        end
        for (int s = 1; s <= seg_total; s++) begin
            if (!ack_bits[s-1]) begin
                queue_result(KIND_SEND, COUNT_W'(s),
                             (s == seg_total) ? final_len : LEN_W'(SEGMENT_BYTES),
                             STAT_OK, s == last_open);
            end
        end
    endfunction

    function automatic void predict_sender(sab_item_t it);
        logic [COUNT_W-1:0] cnt;
        if (it.opcode == OP_START) begin
            active_items++;
            cnt = (it.count == 0) ? COUNT_W'(1) : it.count;
            if (cnt > SEGMENTS_PER_BLOCK) cnt = COUNT_W'(SEGMENTS_PER_BLOCK);
            cur_block   = it.block;
            seg_total   = cnt;
            final_len   = (it.len > SEGMENT_BYTES) ? LEN_W'(SEGMENT_BYTES) : it.len;
            ack_bits    = '0;
            acked_count = '0;
            retry_count = '0;
            blk_busy    = 1'b1;
            queue_unacked();
        end else if (blk_busy && it.opcode == OP_ACK) begin
            active_items++;
            if (it.sess != session_reg || it.ablk != cur_block) begin
                close_block(KIND_FAIL, STAT_INVALID);
            end else if (it.aseg < 1 || it.aseg > seg_total) begin
                close_block(KIND_FAIL, STAT_INVALID);
            end else if (ack_bits[it.aseg-1]) begin
                close_block(KIND_FAIL, STAT_DUPLICATE);
            end else begin
                ack_bits[it.aseg-1] = 1'b1;
                acked_count++;
                if (acked_count >= seg_total) close_block(KIND_DONE, STAT_OK);
            end
        end else if (blk_busy && it.opcode == OP_TIMEOUT) begin
            active_items++;
            if (retry_count >= retry_limit) begin
                close_block(KIND_FAIL, STAT_RETRY_FAIL);
            end else begin
                retry_count++;
                queue_unacked();
            end
        end
    endfunction

    //--------------------------------------------------------------------------
    // Stream helpers
    //--------------------------------------------------------------------------
    function automatic int gap_length(bit calm);
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic sab_item_t junk_item();
        sab_item_t it;
        it.opcode = OP_RESERVED;
        it.block  = BLOCK_W'($urandom);
        it.count  = COUNT_W'($urandom);
        it.len    = LEN_W'($urandom);
        it.sess   = SESSION_W'($urandom);
        it.ablk   = BLOCK_W'($urandom);
        it.aseg   = ACKSEG_W'($urandom);
        return it;
    endfunction

    function automatic sab_item_t start_item(logic [BLOCK_W-1:0] blk, logic [COUNT_W-1:0] cnt,
                                             logic [LEN_W-1:0] len);
        sab_item_t it;
        it        = junk_item();
        it.opcode = OP_START;
        it.block  = blk;
        it.count  = cnt;
        it.len    = len;
        return it;
    endfunction

    function automatic sab_item_t ack_item(logic [SESSION_W-1:0] sess, logic [BLOCK_W-1:0] blk,
                                           logic [ACKSEG_W-1:0] seg);
        sab_item_t it;
        it        = junk_item();
        it.opcode = OP_ACK;
        it.sess   = sess;
        it.ablk   = blk;
        it.aseg   = seg;
        return it;
    endfunction

    function automatic sab_item_t tick_item();
        sab_item_t it;
        it        = junk_item();
        it.opcode = OP_TIMEOUT;
        return it;
    endfunction

    // Called at a rising edge; returns after acceptance and any idle gap.
    task automatic send_item(input sab_item_t it);
        int gap;
        s_tvalid <= 1'b1;
        s_tuser  <= it.opcode;
        s_tdata  <= S_TDATA_W'({it.aseg, it.ablk, it.sess, it.len, it.count, it.block});
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        predict_sender(it);
        if ($urandom_range(0, 24) == 0) tx_calm = !tx_calm;
        gap = gap_length(tx_calm);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    // Wait until every expected result is out and the block has gone quiet.
    task automatic settle();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_ADDR_W-1:0] addr,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= addr;
        cfg_wdata <= data;
        @(posedge aclk);
        if (addr == REG_SESSION_ID) session_reg = data[SESSION_W-1:0];
        else retry_limit = data[RETRY_W-1:0];
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
    endtask

    //--------------------------------------------------------------------------
    // Result checking and receiver stalls
    //--------------------------------------------------------------------------
    function automatic void check_field(string name, int want, int got);
        if (want != got) begin
            $error("%s mismatch: expected %0d, got %0d", name, want, got);
            fail_count++;
        end
    endfunction

    always @(posedge aclk) begin
        sab_result_t want;
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results pending",
                     cycle_count, pending_results.size());
            $display("CHECK FAILED");
            $finish;
        end else begin
            if (aresetn && m_tvalid && m_tready) begin
                results_seen++;
                if (pending_results.size() == 0) begin
                    $error("unexpected result item: kind %0d tdata %h", m_tuser, m_tdata);
                    fail_count++;
                end else begin
                    want = pending_results.pop_front();
                    check_field("kind", want.kind, m_tuser);
                    check_field("out_block", want.block, m_tdata[15:0]);
                    check_field("segment number", want.seg, m_tdata[19:16]);
                    check_field("segment_bytes", want.bytes, m_tdata[30:20]);
                    check_field("status", want.status, m_tdata[32:31]);
                    check_field("last_of_run", want.last, m_tlast);
                end
            end
            if ($urandom_range(0, 299) == 0) rx_calm = !rx_calm;
            if (rx_wait > 0) begin
                m_tready <= 1'b0;
                rx_wait--;
            end else begin
                m_tready <= 1'b1;
                rx_wait = gap_length(rx_calm);
            end
        end
    end

    //--------------------------------------------------------------------------
    // Tests
    //--------------------------------------------------------------------------
    task automatic test_idle_items();
        send_item(ack_item('0, '0, 16'd1));
        send_item(tick_item());
        send_item(junk_item());
    endtask

    // Reset values: session 0 and three resend rounds.
    task automatic test_default_config_block();
        send_item(start_item(16'h0000, 4'd1, 11'd0));
        send_item(ack_item(16'h0000, 16'h0000, 16'd1));
        send_item(start_item(16'hFFFF, 4'd8, 11'd1024));
        repeat (4) send_item(tick_item());
    endtask

    task automatic test_start_limits();
        send_item(start_item(16'h1234, 4'd0, 11'd2047));
        // A new start replaces the open block without any result for it.
        send_item(start_item(16'h8001, 4'd15, 11'd1025));
        send_item(junk_item());
        send_item(ack_item(16'h0000, 16'h8001, 16'd9));
    endtask

    task automatic test_ack_faults();
        settle();
        write_reg(REG_SESSION_ID, 16'hFFFF);
        send_item(start_item(16'h00FF, 4'd4, 11'd7));
        send_item(ack_item(16'h0000, 16'h00FF, 16'd1));
        send_item(start_item(16'h00FF, 4'd4, 11'd7));
        send_item(ack_item(16'hFFFF, 16'h00FF, 16'd2));
        send_item(ack_item(16'hFFFF, 16'h00FF, 16'd2));
        send_item(start_item(16'h7777, 4'd2, 11'd512));
        send_item(ack_item(16'hFFFF, 16'h7776, 16'd1));
        send_item(start_item(16'h7777, 4'd2, 11'd512));
        send_item(ack_item(16'hFFFF, 16'h7777, 16'hFFFF));
    endtask

    task automatic test_retry_limits();
        settle();
        // With no resend rounds allowed the first tick fails the block.
        write_reg(REG_MAX_RETRIES, 16'd0);
        send_item(start_item(16'h0042, 4'd3, 11'd100));
        send_item(tick_item());
        settle();
        write_reg(REG_MAX_RETRIES, 16'd1);
        send_item(start_item(16'h0043, 4'd3, 11'd100));
        send_item(ack_item(session_reg, 16'h0043, 16'd3));
        send_item(tick_item());
        send_item(tick_item());
    endtask

    // Noise between blocks: acks and ticks while idle, and the unused opcode.
    function automatic logic [OPCODE_W-1:0] OP_OPCODE_PICK();
        case ($urandom_range(0, 2))
            0:       return OP_ACK;
            1:       return OP_TIMEOUT;
            default: return OP_RESERVED;
        endcase
    endfunction

    task automatic run_random_block();
        sab_item_t it;
        int r;
        int steps;
        int s;
        logic [15:0] flip;
        if ($urandom_range(0, 6) == 0) begin
            it = junk_item();
            it.opcode = OP_OPCODE_PICK();
            send_item(it);
        end
        r = $urandom_range(0, 9);
        it = start_item(BLOCK_W'($urandom),
                        (r < 8) ? COUNT_W'($urandom_range(1, 8)) : COUNT_W'($urandom),
                        (r < 7) ? LEN_W'($urandom_range(0, 1024)) : LEN_W'($urandom));
        send_item(it);
        steps = 0;
        while (blk_busy && steps < 40) begin
            steps++;
            r = $urandom_range(0, 99);
            flip = 16'($urandom_range(1, 65535));
            if (r < 70) begin
                s = $urandom_range(1, seg_total);
                while (ack_bits[s-1]) s = $urandom_range(1, seg_total);
                it = ack_item(session_reg, cur_block, ACKSEG_W'(s));
            end else if (r < 84) begin
                it = tick_item();
            end else if (r < 88 && ack_bits != 0) begin
                s = $urandom_range(1, seg_total);
                while (!ack_bits[s-1]) s = $urandom_range(1, seg_total);
                it = ack_item(session_reg, cur_block, ACKSEG_W'(s));
            end else if (r < 92) begin
                it = ack_item(session_reg ^ flip, cur_block, ACKSEG_W'(1));
            end else if (r < 95) begin
                it = ack_item(session_reg, cur_block ^ flip, ACKSEG_W'(1));
            end else if (r < 98) begin
                it = ack_item(session_reg, cur_block,
                              ($urandom_range(0, 2) == 0) ? ACKSEG_W'(0)
                                  : ACKSEG_W'($urandom_range(seg_total + 1, 65535)));
            end else if (r < 99) begin
                it = junk_item();
            end else begin
                it = start_item(BLOCK_W'($urandom), COUNT_W'($urandom_range(1, 8)),
                                LEN_W'($urandom_range(0, 1024)));
            end
            send_item(it);
        end
    endtask

    task automatic test_random_traffic();
        int goal;
        for (int ph = 0; ph < 6; ph++) begin
            settle();
            case (ph)
                0: begin
                    write_reg(REG_SESSION_ID, 16'hFFFF);
                    write_reg(REG_MAX_RETRIES, 16'd15);
                end
                1: begin
                    write_reg(REG_SESSION_ID, 16'h0000);
                    write_reg(REG_MAX_RETRIES, 16'd1);
                end
                default: begin
                    write_reg(REG_SESSION_ID, CFG_DATA_W'($urandom));
                    write_reg(REG_MAX_RETRIES, CFG_DATA_W'($urandom_range(1, 15)));
                end
            endcase
            goal = active_items + PHASE_ITEMS;
            while (active_items < goal) run_random_block();
        end
    endtask

    initial begin
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_idle_items();
        test_default_config_block();
        test_start_limits();
        test_ack_faults();
        test_retry_limits();
        test_random_traffic();
        settle();
        $display("%0d items acted on, %0d result items checked", active_items, results_seen);
        $display("%0d blocks finished, %0d blocks failed, %0d mismatches",
                 blocks_done, blocks_failed, fail_count);
        if (fail_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
